[hw/rtl/rotary_dial_pulse_decoder_macros.svh]
// assertion macros shared by the rotary dial decoder checker
`ifndef ROTARY_DIAL_PULSE_DECODER_MACROS_SVH
`define ROTARY_DIAL_PULSE_DECODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RDPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotary dial decoder: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define RDPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotary dial decoder: next-cycle check failed");

`endif

[hw/rtl/rdpd_pkg.sv]
// shared types and constants of the rotary dial decoder
`timescale 1ns / 1ps

package rdpd_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 8;
    localparam int CFG_WIDTH           = 8;
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 8'd15;
    localparam int DIGIT_WIDTH         = 4;
    localparam logic [DIGIT_WIDTH-1:0] TALLY_MAX  = 4'd15;
    localparam logic [DIGIT_WIDTH-1:0] TALLY_TEN  = 4'd10;
    localparam int QUEUE_DEPTH         = 2;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TAKE   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_LOW  = 3'b010,
        PH_HIGH = 3'b100
    } phase_t;

    // classified item handed from the front to the back
    typedef struct packed {
        logic is_take;
        logic ready_level;
        logic pulse_level;
    } item_t;

endpackage

[hw/rtl/rdpd_front.sv]
// input stage: accepts transactions and classifies them
`timescale 1ns / 1ps

module rdpd_front
    import rdpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  op,
    input  logic  ready_level,
    input  logic  pulse_level,
    output logic  push,
    output item_t push_item,
    input  logic  q_full
);

    logic  f_valid_reg;
    logic  f_valid_next;
    item_t f_item_reg;
    logic  accept;

    assign push      = f_valid_reg && !q_full;
    assign push_item = f_item_reg;
    assign in_ready  = !f_valid_reg || !q_full;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_item_reg.is_take     <= (op_t'(op) == OP_TAKE);
            f_item_reg.ready_level <= ready_level;
            f_item_reg.pulse_level <= pulse_level;
        end
    end

endmodule

[hw/rtl/rdpd_queue.sv]
// short queue between the front and the back
`timescale 1ns / 1ps

module rdpd_queue
    import rdpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/rdpd_back.sv]
// execution stage: debounce, pulse counting and result register
`timescale 1ns / 1ps

module rdpd_back
    import rdpd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   head_valid,
    input  item_t                  head_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   digit_valid,
    output logic [DIGIT_WIDTH-1:0] digit
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [CFG_WIDTH-1:0]   debounce_reg;
    logic                   ready_prev_reg;
    logic                   ready_prev_next;
    logic                   pulse_prev_reg;
    logic                   pulse_prev_next;
    logic [COUNT_WIDTH-1:0] stable_count_reg;
    logic [COUNT_WIDTH-1:0] stable_count_next;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [DIGIT_WIDTH-1:0] tally_reg;
    logic [DIGIT_WIDTH-1:0] tally_next;
    logic                   pending_reg;
    logic                   pending_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   res_valid_reg;
    logic [DIGIT_WIDTH-1:0] res_digit_reg;
    logic                   res_valid;
    logic [DIGIT_WIDTH-1:0] res_digit;
    logic                   rdy;
    logic                   pls;

    assign pop = head_valid && (!out_valid_reg || out_ready);
    assign rdy = head_item.ready_level;
    assign pls = head_item.pulse_level;

    always_comb
    begin
        ready_prev_next   = ready_prev_reg;
        pulse_prev_next   = pulse_prev_reg;
        stable_count_next = stable_count_reg;
        phase_next        = phase_reg;
        tally_next        = tally_reg;
        pending_next      = pending_reg;
        if (pop)
        begin
            if (head_item.is_take)
            begin
                pending_next = 1'b0;
            end
            else
            begin
                ready_prev_next = rdy;
                pulse_prev_next = pls;
                if (rdy != ready_prev_reg || pls != pulse_prev_reg)
                begin
                    stable_count_next = '0;
                end
                else
                begin
                    if (stable_count_reg != COUNT_MAX)
                    begin
                        stable_count_next = stable_count_reg + COUNT_WIDTH'(1);
                    end
                    if (CMP_W'(stable_count_next) > CMP_W'(debounce_reg))
                    begin
                        case (phase_reg)
                            PH_LOW:
                            begin
                                if (rdy && pls)
                                begin
                                    phase_next = PH_HIGH;
                                    if (tally_reg != TALLY_MAX)
                                    begin
                                        tally_next = tally_reg + DIGIT_WIDTH'(1);
                                    end
                                end
                                else if (rdy && !pls)
                                begin
                                    // dial complete: keep only counts of one to ten
                                    phase_next = PH_WAIT;
                                    if (tally_reg inside {[4'd1:TALLY_TEN]})
                                    begin
                                        pending_next = 1'b1;
                                        if (tally_reg == TALLY_TEN)
                                        begin
                                            tally_next = '0;
                                        end
                                    end
                                end
                            end
                            PH_HIGH:
                            begin
                                if (!rdy && !pls)
                                begin
                                    phase_next = PH_LOW;
                                end
                            end
                            default:
                            begin
                                // new dial drops any untaken digit
                                if (!rdy && !pls)
                                begin
                                    phase_next   = PH_LOW;
                                    pending_next = 1'b0;
                                    tally_next   = '0;
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    // a take reports the digit held before it, a sample the one after it
    always_comb
    begin
        if (head_item.is_take)
        begin
            res_valid = pending_reg;
            res_digit = pending_reg ? tally_reg : '0;
        end
        else
        begin
            res_valid = pending_next;
            res_digit = pending_next ? tally_next : '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= DEBOUNCE_RESET;
            ready_prev_reg   <= 1'b1;
            pulse_prev_reg   <= 1'b1;
            stable_count_reg <= '0;
            phase_reg        <= PH_WAIT;
            tally_reg        <= '0;
            pending_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                debounce_reg <= cfg_data;
            end
            ready_prev_reg   <= ready_prev_next;
            pulse_prev_reg   <= pulse_prev_next;
            stable_count_reg <= stable_count_next;
            phase_reg        <= phase_next;
            tally_reg        <= tally_next;
            pending_reg      <= pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_valid_reg <= res_valid;
            res_digit_reg <= res_digit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digit_valid = res_valid_reg;
    assign digit       = res_digit_reg;

endmodule

[hw/rtl/rotary_dial_pulse_decoder.sv]
// top level of the rotary dial pulse decoder
`timescale 1ns / 1ps

// Rotary dial pulse decoder. Each input transaction is either a one-tick
// sample of the dial's ready and pulse contacts (op 0) or a request to take
// the pending digit (op 1); every transaction yields exactly one result
// transaction carrying digit_valid and digit (0 to 9, zero when none).
// Contacts are debounced by a saturating stable-tick counter of COUNT_WIDTH
// bits; once it exceeds debounce_ticks a waiting / low pulse / high pulse
// machine counts pulses, and a count of one to ten becomes the digit when
// the ready contact returns high (ten reads as zero). Throughput is one
// transaction per clock while out_ready holds; a transaction passes three
// register stages in order (input register, two-entry queue, result
// register), the first loaded at the accepting edge and the last offering
// its result on the output. Until the queue and the input register fill,
// the input side can keep taking samples while a result waits for out_ready. The
// debounce_ticks register (reset 15) is written through cfg_valid/cfg_data
// and must only be changed while no transaction is in flight.
module rotary_dial_pulse_decoder
    import rdpd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample / take transactions
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   op,
    input  logic                   ready_level,
    input  logic                   pulse_level,
    // result transactions
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   digit_valid,
    output logic [DIGIT_WIDTH-1:0] digit,
    // debounce_ticks write port
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_WIDTH-1:0]   cfg_data
);

    logic  push;
    item_t push_item;
    logic  q_full;
    logic  pop;
    logic  head_valid;
    item_t head_item;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // front: registers and classifies each incoming transaction
    rdpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .ready_level (ready_level),
        .pulse_level (pulse_level),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    // decoupling queue
    rdpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // back: debounce, phase machine and result register
    rdpd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit_valid (digit_valid),
        .digit       (digit)
    );

endmodule

[hw/rtl/rdpd_checker.sv]
// port checker of the rotary dial decoder and its bind
`timescale 1ns / 1ps
`include "rotary_dial_pulse_decoder_macros.svh"

module rdpd_checker
    import rdpd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   digit_valid,
    input logic [DIGIT_WIDTH-1:0] digit
);

    // no digit means a zero digit field
    `RDPD_ASSERT_IMPLY(a_zero_when_none, clk, rst_n, out_valid && !digit_valid, digit == '0)
    // a reported digit is a decimal digit
    `RDPD_ASSERT_IMPLY(a_decimal_digit, clk, rst_n, out_valid && digit_valid, digit <= 4'd9)
    // a stalled result stays offered
    `RDPD_ASSERT_NEXT(a_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid)
    // a stalled result keeps its payload
    `RDPD_ASSERT_NEXT(a_payload_holds, clk, rst_n, out_valid && !out_ready, $stable(digit) && $stable(digit_valid))

endmodule

bind rotary_dial_pulse_decoder rdpd_checker u_rdpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digit_valid (digit_valid),
    .digit       (digit)
);
